// ----- sv/bracket_balance_checker_assert.svh -----
// Assertion macros shared by the bracket balance checker.
// Each macro expects signals named clock and reset in the using scope.
`ifndef BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_ASSERT_SVH

// Same-cycle implication.
`define BBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/bbc_pkg.sv -----
package bbc_pkg;

   // One input transaction.
   typedef struct packed {
      logic       action;
      logic [7:0] char_code;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic [1:0]  verdict;
      logic [15:0] error_position;
   } rsp_type;

   localparam logic ActionChar = 1'b0;
   localparam logic ActionEnd  = 1'b1;

   // Token class handed from the front to the back.
   typedef enum logic [1:0] {
      TOK_OTHER,
      TOK_OPEN,
      TOK_CLOSE,
      TOK_END
   } tok_op_type;

   typedef struct packed {
      tok_op_type op;
      logic [1:0] kind;
   } token_type;

   localparam logic [1:0] KindNone   = 2'd0;
   localparam logic [1:0] KindBrace  = 2'd1;
   localparam logic [1:0] KindSquare = 2'd2;
   localparam logic [1:0] KindParen  = 2'd3;

   localparam logic [7:0] CharBraceOpen   = 8'h7B;
   localparam logic [7:0] CharSquareOpen  = 8'h5B;
   localparam logic [7:0] CharParenOpen   = 8'h28;
   localparam logic [7:0] CharBraceClose  = 8'h7D;
   localparam logic [7:0] CharSquareClose = 8'h5D;
   localparam logic [7:0] CharParenClose  = 8'h29;
   localparam logic [7:0] CharSpace       = 8'h20;
   localparam logic [7:0] CharBlankLow    = 8'h09;
   localparam logic [7:0] CharBlankHigh   = 8'h0D;

   localparam logic [1:0] VerdictBalanced = 2'd0;
   localparam logic [1:0] VerdictUnmatched = 2'd1;
   localparam logic [1:0] VerdictUnclosed = 2'd2;
   localparam logic [1:0] VerdictOverflow = 2'd3;

   localparam int QueueDepth = 2;

endpackage

// ----- sv/bbc_front.sv -----
module bbc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bbc_pkg::req_type   req_payload,
   output logic               q_valid,
   output bbc_pkg::token_type q_tok,
   input  logic               q_pop
);

   localparam int PtrW = $clog2(bbc_pkg::QueueDepth);
   localparam int CntW = $clog2(bbc_pkg::QueueDepth + 1);

   bbc_pkg::token_type q_data_ff [bbc_pkg::QueueDepth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;

   bbc_pkg::token_type tok;
   logic               keep;
   logic               push;

   // Classify the character; whitespace is dropped here and never reaches the back.
   always_comb begin
      tok.op   = bbc_pkg::TOK_OTHER;
      tok.kind = bbc_pkg::KindNone;
      keep     = 1'b1;
      if (req_payload.action == bbc_pkg::ActionEnd) begin
         tok.op = bbc_pkg::TOK_END;
      end else if (req_payload.char_code inside {bbc_pkg::CharSpace,
                   [bbc_pkg::CharBlankLow:bbc_pkg::CharBlankHigh]}) begin
         keep = 1'b0;
      end else begin
         case (req_payload.char_code)
            bbc_pkg::CharBraceOpen: begin
               tok.op   = bbc_pkg::TOK_OPEN;
               tok.kind = bbc_pkg::KindBrace;
            end
            bbc_pkg::CharSquareOpen: begin
               tok.op   = bbc_pkg::TOK_OPEN;
               tok.kind = bbc_pkg::KindSquare;
            end
            bbc_pkg::CharParenOpen: begin
               tok.op   = bbc_pkg::TOK_OPEN;
               tok.kind = bbc_pkg::KindParen;
            end
            bbc_pkg::CharBraceClose: begin
               tok.op   = bbc_pkg::TOK_CLOSE;
               tok.kind = bbc_pkg::KindBrace;
            end
            bbc_pkg::CharSquareClose: begin
               tok.op   = bbc_pkg::TOK_CLOSE;
               tok.kind = bbc_pkg::KindSquare;
            end
            bbc_pkg::CharParenClose: begin
               tok.op   = bbc_pkg::TOK_CLOSE;
               tok.kind = bbc_pkg::KindParen;
            end
            default: begin
               tok.op   = bbc_pkg::TOK_OTHER;
               tok.kind = bbc_pkg::KindNone;
            end
         endcase
      end
   end

   assign req_ready = (cnt_ff != CntW'(bbc_pkg::QueueDepth));
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (cnt_ff != '0);
   assign q_tok     = q_data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_data_ff[wr_ptr_ff] <= tok;
      end
   end

endmodule

// ----- sv/bbc_back.sv -----
module bbc_back #(
   parameter int STACK_DEPTH = 512,
   parameter int POS_WIDTH   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  bbc_pkg::token_type q_tok,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bbc_pkg::rsp_type   rsp_payload
);

   localparam int AddrW = $clog2(STACK_DEPTH);
   localparam int SpW   = $clog2(STACK_DEPTH + 1);
   localparam int EntW  = 2 + POS_WIDTH;

   logic [EntW-1:0]      mem [STACK_DEPTH];
   logic [EntW-1:0]      rd_data_ff;
   logic                 byp_ff, byp_in;
   logic [EntW-1:0]      byp_data_ff;

   logic [SpW-1:0]       sp_ff, sp_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic                 err_ff, err_in;
   logic [1:0]           err_verdict_ff, err_verdict_in;
   logic [POS_WIDTH-1:0] err_pos_ff, err_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bbc_pkg::rsp_type     rsp_payload_ff, rsp_payload_in;

   logic [EntW-1:0]      top;
   logic [1:0]           top_kind;
   logic [POS_WIDTH-1:0] top_pos;
   logic [POS_WIDTH-1:0] pos_next;
   logic                 out_free;
   logic                 wr_en;
   logic [AddrW-1:0]     wr_addr;
   logic [EntW-1:0]      wr_data;
   logic [AddrW-1:0]     rd_addr;
   logic [1:0]           rep_verdict;
   logic [POS_WIDTH-1:0] rep_pos;
   logic [POS_WIDTH+15:0] rep_pos_ext;

   // The memory is read every cycle at the entry that will be on top next cycle.
   // A push writes that same entry, so the written data is forwarded instead.
   assign top      = byp_ff ? byp_data_ff : rd_data_ff;
   assign top_kind = top[EntW-1 -: 2];
   assign top_pos  = top[POS_WIDTH-1:0];
   assign pos_next = (pos_ff == {POS_WIDTH{1'b1}}) ? pos_ff : pos_ff + POS_WIDTH'(1);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = q_valid && ((q_tok.op != bbc_pkg::TOK_END) || out_free);
   assign wr_addr  = sp_ff[AddrW-1:0];
   assign wr_data  = {q_tok.kind, pos_next};

   always_comb begin
      if (err_ff) begin
         rep_verdict = err_verdict_ff;
         rep_pos     = err_pos_ff;
      end else if (sp_ff != '0) begin
         rep_verdict = bbc_pkg::VerdictUnclosed;
         rep_pos     = top_pos;
      end else begin
         rep_verdict = bbc_pkg::VerdictBalanced;
         rep_pos     = '0;
      end
      rep_pos_ext = {16'b0, rep_pos};
   end

   always_comb begin
      sp_in          = sp_ff;
      pos_in         = pos_ff;
      err_in         = err_ff;
      err_verdict_in = err_verdict_ff;
      err_pos_in     = err_pos_ff;
      wr_en          = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (q_pop) begin
         case (q_tok.op)
            bbc_pkg::TOK_END: begin
               rsp_valid_in                  = 1'b1;
               rsp_payload_in.verdict        = rep_verdict;
               rsp_payload_in.error_position = rep_pos_ext[15:0];
               sp_in                         = '0;
               pos_in                        = '0;
               err_in                        = 1'b0;
               err_verdict_in                = '0;
               err_pos_in                    = '0;
            end
            bbc_pkg::TOK_OPEN: begin
               if (!err_ff) begin
                  pos_in = pos_next;
                  if (sp_ff == SpW'(STACK_DEPTH)) begin
                     err_in         = 1'b1;
                     err_verdict_in = bbc_pkg::VerdictOverflow;
                     err_pos_in     = pos_next;
                  end else begin
                     wr_en = 1'b1;
                     sp_in = sp_ff + SpW'(1);
                  end
               end
            end
            bbc_pkg::TOK_CLOSE: begin
               if (!err_ff) begin
                  pos_in = pos_next;
                  if ((sp_ff != '0) && (top_kind == q_tok.kind)) begin
                     sp_in = sp_ff - SpW'(1);
                  end else begin
                     err_in         = 1'b1;
                     err_verdict_in = bbc_pkg::VerdictUnmatched;
                     err_pos_in     = pos_next;
                  end
               end
            end
            default: begin
               if (!err_ff) begin
                  pos_in = pos_next;
               end
            end
         endcase
      end
      rd_addr = AddrW'(sp_in - SpW'(1));
      byp_in  = wr_en && (wr_addr == rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff          <= '0;
         pos_ff         <= '0;
         err_ff         <= 1'b0;
         err_verdict_ff <= '0;
         err_pos_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         byp_ff         <= 1'b0;
      end else begin
         sp_ff          <= sp_in;
         pos_ff         <= pos_in;
         err_ff         <= err_in;
         err_verdict_ff <= err_verdict_in;
         err_pos_ff     <= err_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
         byp_ff         <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      byp_data_ff    <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- sv/bracket_balance_checker.sv -----
// rsp_valid rises once an end-of-text transaction has passed the token queue and the result
// register, when no token waits ahead of it. Throughput: one transaction per cycle while
// the queue has room; the stack takes one push or pop each cycle.
// A two-entry queue between front and back lets either side stall independently.
// Reset is synchronous and active high; it empties the stack and clears all status.
// No clearing pass is needed: stack entries are only read below the stack pointer.
module bracket_balance_checker #(
   parameter int STACK_DEPTH = 512,
   parameter int POS_WIDTH   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bbc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bbc_pkg::rsp_type rsp_payload
);

   // Token channel between the classifier front and the stack engine back.
   logic               q_valid;
   bbc_pkg::token_type q_tok;
   logic               q_pop;

   // End-of-text events on the input channel and on the token channel.
   logic               end_accepted;
   logic               end_taken;

   // The front accepts a transaction whenever its queue has room. Whitespace is
   // consumed there without producing a token, so it never costs a back cycle.
   // Every other character becomes a token carrying its class and bracket kind.
   bbc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_tok       (q_tok),
      .q_pop       (q_pop)
   );

   // The back owns the position counter, the error latch and the bracket stack.
   // The stack lives in a single-port-write, single-read memory whose read is
   // always aimed at the next top entry, so consecutive pops need no bubble.
   // An end-of-text token waits in the queue only while the result register
   // is still occupied by a result that has not been taken.
   bbc_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .POS_WIDTH   (POS_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_tok       (q_tok),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   assign end_accepted = req_valid && req_ready && (req_payload.action == bbc_pkg::ActionEnd);
   assign end_taken    = q_pop && (q_tok.op == bbc_pkg::TOK_END);

   `include "bracket_balance_checker_assert.svh"

   // The back never takes a token from an empty queue.
   `BBC_ASSERT_NOW(a_pop_needs_token, q_pop, q_valid, "token popped from empty queue")

   // An accepted end-of-text transaction always lands in the queue.
   `BBC_ASSERT_NEXT(a_end_queued, end_accepted, q_valid, "end of text dropped by front")

   // Consuming an end-of-text token always presents a result on the next cycle.
   `BBC_ASSERT_NEXT(a_end_reports, end_taken, rsp_valid, "end of text gave no result")

endmodule
